>>> rtl/tar_pkg.sv
// Shared types and constants for the tensor axis reduction core.
// Holds the reduction op codes, register indexes and fixed field widths.
// No dependencies.
package tar_pkg;

  localparam int DATA_W    = 32;
  localparam int ELEM_W    = 16;
  localparam int DIM_REG_W = 13;
  localparam int ADDR_W    = 5;
  localparam int IDX_W     = 3;

  typedef enum logic [1:0] {
    OP_MAX  = 2'd0,
    OP_MIN  = 2'd1,
    OP_SUM  = 2'd2,
    OP_MEAN = 2'd3
  } op_mode_t;

  localparam logic [IDX_W-1:0] REG_OP_MODE = 3'd0;
  localparam logic [IDX_W-1:0] REG_DIM0    = 3'd1;
  localparam logic [IDX_W-1:0] REG_DIM1    = 3'd2;
  localparam logic [IDX_W-1:0] REG_DIM2    = 3'd3;
  localparam logic [IDX_W-1:0] REG_DIM3    = 3'd4;
  localparam logic [IDX_W-1:0] REG_AXIS    = 3'd5;

endpackage

>>> rtl/tensor_axis_reduce_core.sv
// Tensor reduction along one axis (max, min, sum, mean) over Q8.8 elements; needs tar_pkg.
// Partial accumulators live in one synchronous memory of MAX_INNER entries.
// A beat that ends no axis is taken every cycle, its accumulator written back the next.
// A beat that ends an axis passes through the write-back and push states before result_valid
// rises, and the next beat waits for the idle state; a mean first runs the serial divider, and
// a stalled result holds the input off. Reset clears registers and positions, not the memory.
module tensor_axis_reduce_core #(
  parameter int unsigned MAX_INNER = 1024,
  parameter int unsigned MAX_DIM   = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tar_pkg::ADDR_W-1:0]          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                element_valid,
  output logic                                element_ready,
  input  logic signed [tar_pkg::ELEM_W-1:0]   element,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic signed [tar_pkg::DATA_W-1:0]   reduced_value,
  output logic                                final_result
);
  import tar_pkg::*;

  localparam int PosW  = $clog2(MAX_DIM);
  localparam int DimW  = $clog2(MAX_DIM + 1);
  localparam int SlotW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;

  typedef enum logic [1:0] {S_IDLE, S_RMW, S_DIV, S_PUSH} state_t;

  state_t                    state;
  op_mode_t                  op_mode;
  logic [DIM_REG_W-1:0]      dim_reg [4];
  logic [1:0]                reduce_axis;
  logic [PosW-1:0]           pos [4];
  logic [SlotW-1:0]          slot;

  logic signed [ELEM_W-1:0]  x_q;
  logic                      first_q, last_q, final_q;
  logic [SlotW-1:0]          slot_q;
  logic                      fwd_hit;
  logic signed [DATA_W-1:0]  fwd_data;

  logic [DATA_W-1:0]         mem [MAX_INNER];
  logic signed [DATA_W-1:0]  mem_q;

  logic                      div_neg;
  logic [DATA_W-1:0]         div_dvd;
  logic [DimW-1:0]           div_rem, div_den;
  logic [4:0]                div_cnt;
  logic signed [DATA_W-1:0]  res;

  logic [DimW-1:0]           dim_eff [4];
  logic [3:0]                is_last, carry;
  logic [PosW-1:0]           pos_next [4];
  logic [SlotW-1:0]          slot_next;
  logic                      accept, cfg_wr, out_free;
  logic [IDX_W-1:0]          cfg_idx;
  logic signed [DATA_W-1:0]  prev, x_ext, acc;
  logic [DimW:0]             trial;
  logic                      trial_ge;
  logic [DimW-1:0]           rem_step;
  logic [DATA_W-1:0]         q_step;

  assign pready        = 1'b1;
  assign cfg_wr        = psel & penable & pwrite;
  assign cfg_idx       = paddr[ADDR_W-1:2];
  assign element_ready = (state == S_IDLE) || (state == S_RMW && !last_q);
  assign accept        = element_valid & element_ready;
  assign out_free      = !result_valid || result_ready;

  // Dimension lengths as used: zero reads as one, oversize clamps to MAX_DIM.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (dim_reg[i] == '0) begin
        dim_eff[i] = DimW'(1);
      end else if (32'(dim_reg[i]) > MAX_DIM) begin
        dim_eff[i] = DimW'(MAX_DIM);
      end else begin
        dim_eff[i] = DimW'(dim_reg[i]);
      end
      is_last[i] = (({1'b0, pos[i]} + 1'b1) == (PosW + 1)'(dim_eff[i]));
    end
  end

  // Row-major position counter; the innermost dimension always steps.
  always_comb begin
    carry[3] = 1'b1;
    for (int i = 3; i > 0; i--) begin
      carry[i-1] = carry[i] & is_last[i];
    end
    for (int i = 0; i < 4; i++) begin
      if (!carry[i]) begin
        pos_next[i] = pos[i];
      end else if (is_last[i]) begin
        pos_next[i] = '0;
      end else begin
        pos_next[i] = pos[i] + 1'b1;
      end
    end
  end

  // The store index follows the flattened position after the axis, so it simply counts up,
  // wraps after the last memory entry and restarts whenever the carry reaches the axis.
  always_comb begin
    if (carry[reduce_axis] || slot == SlotW'(MAX_INNER - 1)) begin
      slot_next = '0;
    end else begin
      slot_next = slot + 1'b1;
    end
  end

  always_comb begin
    prev  = fwd_hit ? fwd_data : mem_q;
    x_ext = DATA_W'(x_q);
    if (first_q) begin
      acc = x_ext;
    end else begin
      case (op_mode)
        OP_MAX:  acc = (x_ext > prev) ? x_ext : prev;
        OP_MIN:  acc = (x_ext < prev) ? x_ext : prev;
        default: acc = prev + x_ext;
      endcase
    end
  end

  always_comb begin
    trial    = {div_rem, div_dvd[DATA_W-1]};
    trial_ge = trial >= {1'b0, div_den};
    rem_step = trial_ge ? DimW'(trial - {1'b0, div_den}) : trial[DimW-1:0];
    q_step   = {div_dvd[DATA_W-2:0], trial_ge};
  end

  always_comb begin
    case (cfg_idx)
      REG_OP_MODE: prdata = 32'(op_mode);
      REG_DIM0:    prdata = 32'(dim_reg[0]);
      REG_DIM1:    prdata = 32'(dim_reg[1]);
      REG_DIM2:    prdata = 32'(dim_reg[2]);
      REG_DIM3:    prdata = 32'(dim_reg[3]);
      REG_AXIS:    prdata = 32'(reduce_axis);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_RMW) begin
      mem[slot_q] <= acc;
    end
    if (accept) begin
      mem_q <= mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      op_mode      <= OP_SUM;
      reduce_axis  <= '0;
      slot         <= '0;
      fwd_hit      <= 1'b0;
      result_valid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        dim_reg[i] <= DIM_REG_W'(1);
        pos[i]     <= '0;
      end
    end else begin
      if (state == S_PUSH && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end

      if (accept) begin
        x_q      <= element;
        first_q  <= (pos[reduce_axis] == '0);
        last_q   <= is_last[reduce_axis];
        final_q  <= &is_last;
        slot_q   <= slot;
        // The memory returns stale data when the entry is written in the same cycle.
        fwd_hit  <= (state == S_RMW) && (slot == slot_q);
        fwd_data <= acc;
      end

      // A write to a real register (index up to REG_AXIS) restarts the tensor; the store keeps its contents.
      if (cfg_wr && cfg_idx <= REG_AXIS) begin
        slot <= '0;
        for (int i = 0; i < 4; i++) begin
          pos[i] <= '0;
        end
      end else if (accept) begin
        slot <= slot_next;
        pos  <= pos_next;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_RMW;
          end
        end
        S_RMW: begin
          if (!last_q) begin
            state <= accept ? S_RMW : S_IDLE;
          end else if (op_mode == OP_MEAN) begin
            div_neg <= acc[DATA_W-1];
            div_dvd <= acc[DATA_W-1] ? DATA_W'(-acc) : DATA_W'(acc);
            div_rem <= '0;
            div_den <= dim_eff[reduce_axis];
            div_cnt <= '0;
            state   <= S_DIV;
          end else begin
            res   <= acc;
            state <= S_PUSH;
          end
        end
        S_DIV: begin
          div_rem <= rem_step;
          div_dvd <= q_step;
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == '1) begin
            res   <= div_neg ? -$signed(q_step) : $signed(q_step);
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (out_free) begin
            reduced_value <= res;
            final_result  <= final_q;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (cfg_wr) begin
        case (cfg_idx)
          REG_OP_MODE: op_mode     <= op_mode_t'(pwdata[1:0]);
          REG_DIM0:    dim_reg[0]  <= pwdata[DIM_REG_W-1:0];
          REG_DIM1:    dim_reg[1]  <= pwdata[DIM_REG_W-1:0];
          REG_DIM2:    dim_reg[2]  <= pwdata[DIM_REG_W-1:0];
          REG_DIM3:    dim_reg[3]  <= pwdata[DIM_REG_W-1:0];
          REG_AXIS:    reduce_axis <= pwdata[1:0];
          default:     ;
        endcase
      end
    end
  end

`ifndef ASSERT_OFF
  a_reset_pos: assert property (@(posedge clk)
    rst |=> (slot == '0 && pos[0] == '0 && pos[3] == '0))
    else $error("positions not cleared by reset");

  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_cnt != '1) |=> (state == S_DIV))
    else $error("divider left before its last step");

  a_push_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH && out_free) |=> (result_valid && state == S_IDLE))
    else $error("result not presented from push state");

  a_fwd_src: assert property (@(posedge clk) disable iff (rst)
    (state == S_RMW && fwd_hit) |-> $past(state == S_RMW))
    else $error("forwarding without a write back in flight");
`endif

endmodule

>>> sim/tb_tensor_axis_reduce_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for tensor_axis_reduce_core: streams Q8.8 tensors through the
// core, predicts every reduced beat in step with it and compares each field as it leaves.
// Depends on tar_pkg and the core RTL only.
module tb_tensor_axis_reduce_core;
  import tar_pkg::*;

  localparam int STORE_DEPTH  = 1024;
  localparam int LEN_CAP      = 4096;
  // Covers the result path and the serial divider of a mean, with margin.
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } reduced_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [ADDR_W-1:0]        paddr = '0;
  logic [31:0]              pwdata = '0;
  logic [31:0]              prdata;
  logic                     pready;
  logic                     element_valid = 1'b0;
  logic                     element_ready;
  logic signed [ELEM_W-1:0] element = '0;
  logic                     result_valid;
  logic                     result_ready = 1'b0;
  logic signed [DATA_W-1:0] reduced_value;
  logic                     final_result;

  // Predictor state: register shadows, walk position and partial accumulators.
  op_mode_t                 red_op;
  logic [DIM_REG_W-1:0]     dim_reg [4];
  logic [1:0]               red_axis;
  int unsigned              walk_pos [4];
  logic signed [DATA_W-1:0] partial_acc [STORE_DEPTH];
  reduced_t                 reduced_q [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int holdoff_len    = 0;
  int holdoff_seq    = 0;
  int holdoff_ack    = 0;
  int stall_left     = 0;
  int mismatches     = 0;
  int cycle_count    = 0;

  tensor_axis_reduce_core #(
    .MAX_INNER(STORE_DEPTH),
    .MAX_DIM  (LEN_CAP)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .element_valid(element_valid),
    .element_ready(element_ready),
    .element      (element),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .reduced_value(reduced_value),
    .final_result (final_result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got 0x%08h, wanted 0x%08h at cycle %0d",
             what, got, want, cycle_count);
    mismatches++;
  endtask

  function automatic int unsigned used_len(input logic [DIM_REG_W-1:0] raw);
    if (raw == 0)
      return 1;
    if (raw > LEN_CAP)
      return LEN_CAP;
    return int'(raw);
  endfunction

  function automatic void predict_beat(input logic signed [ELEM_W-1:0] x);
    int unsigned              len [4];
    int unsigned              span;
    int unsigned              slot;
    logic signed [DATA_W-1:0] acc;
    logic signed [DATA_W-1:0] prior;
    int                       divisor;
    bit                       tensor_end;
    bit                       carry;
    reduced_t                 r;
    for (int k = 0; k < 4; k++) begin
      len[k] = used_len(dim_reg[k]);
      if (walk_pos[k] >= len[k])
        walk_pos[k] = 0;
    end
    // The store index wraps modulo its depth; 32-bit wrap keeps that residue intact.
    span = 0;
    for (int k = int'(red_axis) + 1; k < 4; k++)
      span = span * len[k] + walk_pos[k];
    slot = span % STORE_DEPTH;

    if (walk_pos[red_axis] == 0) begin
      acc = x;
    end else begin
      prior = partial_acc[slot];
      case (red_op)
        OP_MAX:  acc = (x > prior) ? x : prior;
        OP_MIN:  acc = (x < prior) ? x : prior;
        default: acc = prior + x;
      endcase
    end
    partial_acc[slot] = acc;

    tensor_end = 1'b1;
    for (int k = 0; k < 4; k++)
      if (walk_pos[k] + 1 != len[k])
        tensor_end = 1'b0;

    if (walk_pos[red_axis] + 1 == len[red_axis]) begin
      divisor = len[red_axis];
      r.value = (red_op == OP_MEAN) ? acc / divisor : acc;
      r.last  = tensor_end;
      reduced_q.push_back(r);
    end

    carry = 1'b1;
    for (int k = 3; k >= 0; k--) begin
      if (carry) begin
        if (walk_pos[k] + 1 < len[k]) begin
          walk_pos[k]++;
          carry = 1'b0;
        end else begin
          walk_pos[k] = 0;
        end
      end
    end
  endfunction

  // Every accepted element beat is fed to the predictor at the edge that takes it.
  always @(posedge clk) begin
    if (!rst && element_valid && element_ready)
      predict_beat(element);
  end

  always @(posedge clk) begin
    reduced_t want;
    if (!rst && result_valid && result_ready) begin
      if (reduced_q.size() == 0) begin
        report_mismatch("result beat with nothing outstanding", reduced_value, '0);
      end else begin
        want = reduced_q.pop_front();
        if (reduced_value !== want.value)
          report_mismatch("reduced_value", reduced_value, want.value);
        if (final_result !== want.last)
          report_mismatch("final_result", {31'd0, final_result}, {31'd0, want.last});
      end
    end
  end

  always @(posedge clk) begin
    if (holdoff_seq != holdoff_ack) begin
      holdoff_ack = holdoff_seq;
      stall_left  = holdoff_len;
    end
    if (stall_left > 0) begin
      stall_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // One APB transfer, then a wait with the bus idle; writes update the shadows.
  task automatic apb_transfer(input bit wr, input logic [IDX_W-1:0] idx,
                              input logic [31:0] data, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (wr) begin
      case (idx)
        REG_OP_MODE: red_op     = op_mode_t'(data[1:0]);
        REG_DIM0:    dim_reg[0] = data[DIM_REG_W-1:0];
        REG_DIM1:    dim_reg[1] = data[DIM_REG_W-1:0];
        REG_DIM2:    dim_reg[2] = data[DIM_REG_W-1:0];
        REG_DIM3:    dim_reg[3] = data[DIM_REG_W-1:0];
        REG_AXIS:    red_axis   = data[1:0];
        default: ;
      endcase
      // Only a write to a real register restarts the tensor.
      if (idx <= REG_AXIS)
        foreach (walk_pos[k]) walk_pos[k] = 0;
    end
    @(posedge clk);
  endtask

  task automatic check_registers();
    logic [IDX_W-1:0] idx;
    logic [31:0]      want;
    logic [31:0]      got;
    for (int i = 0; i <= int'(REG_AXIS); i++) begin
      idx = IDX_W'(i);
      case (idx)
        REG_OP_MODE: want = {30'd0, red_op};
        REG_AXIS:    want = {30'd0, red_axis};
        default:     want = {{(32 - DIM_REG_W){1'b0}}, dim_reg[2'(idx - REG_DIM0)]};
      endcase
      apb_transfer(1'b0, idx, '0, got);
      if (got !== want)
        report_mismatch("register readback", got, want);
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (reduced_q.size() != 0);
    // A beat that completes nothing may still be writing back its accumulator.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input op_mode_t op, input logic [DIM_REG_W-1:0] d [4],
                           input logic [1:0] axis);
    logic [31:0] junk;
    logic [31:0] rd;
    wait_idle();
    junk = $urandom;
    apb_transfer(1'b1, REG_OP_MODE, {junk[31:2], op}, rd);
    apb_transfer(1'b1, REG_DIM0, {{(32 - DIM_REG_W){1'b0}}, d[0]}, rd);
    apb_transfer(1'b1, REG_DIM1, {{(32 - DIM_REG_W){1'b0}}, d[1]}, rd);
    apb_transfer(1'b1, REG_DIM2, {{(32 - DIM_REG_W){1'b0}}, d[2]}, rd);
    apb_transfer(1'b1, REG_DIM3, {{(32 - DIM_REG_W){1'b0}}, d[3]}, rd);
    junk = $urandom;
    apb_transfer(1'b1, REG_AXIS, {junk[31:2], axis}, rd);
  endtask

  // Offers one element beat and returns at the edge that accepts it; valid stays high.
  task automatic send_element(input logic signed [ELEM_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      element_valid <= 1'b0;
      @(posedge clk);
    end
    element_valid <= 1'b1;
    element       <= v;
    do @(posedge clk); while (!element_ready);
  endtask

  function automatic logic signed [ELEM_W-1:0] rand_element();
    case ($urandom_range(7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      3:       return '1;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  task automatic send_elements(input logic signed [ELEM_W-1:0] vals [$]);
    foreach (vals[i]) send_element(vals[i]);
    element_valid <= 1'b0;
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_element(rand_element());
    element_valid <= 1'b0;
  endtask

  // Reset values of the registers, then single-element tensors summed as they arrive.
  task automatic test_register_defaults();
    logic signed [ELEM_W-1:0] vals [$];
    check_registers();
    vals = '{16'sh7FFF, 16'sh8000, 16'sh5555, 16'shAAAA};
    send_elements(vals);
  endtask

  // Max, min and mean over rows of three; the second row checks truncation toward zero.
  task automatic test_each_reduction();
    logic signed [ELEM_W-1:0] vals [$];
    logic [DIM_REG_W-1:0]     dims [4];
    op_mode_t                 ops [3];
    ops  = '{OP_MAX, OP_MIN, OP_MEAN};
    dims = '{13'd1, 13'd1, 13'd2, 13'd3};
    vals = '{16'sh7FFF, 16'sh8000, -16'sd1, -16'sd2, -16'sd2, -16'sd1};
    foreach (ops[i]) begin
      configure(ops[i], dims, 2'd3);
      send_elements(vals);
    end
  endtask

  // A zero length counts as one; writes to unused indexes leave the walk alone, while a
  // write to a real register in mid-tensor starts over.
  task automatic test_restart_and_ignored_writes();
    logic signed [ELEM_W-1:0] vals [$];
    logic [DIM_REG_W-1:0]     dims [4];
    logic [31:0]              rd;
    dims = '{13'd0, 13'd2, 13'd1, 13'd3};
    configure(OP_MAX, dims, 2'd1);
    vals = '{16'sh0100, -16'sh0200};
    send_elements(vals);
    wait_idle();
    apb_transfer(1'b1, REG_SPARE_A, $urandom, rd);
    apb_transfer(1'b1, REG_SPARE_B, $urandom, rd);
    vals = '{16'sh7FFF, 16'sh8000, -16'sd1, 16'sh0300};
    send_elements(vals);
    vals = '{16'sh0001, 16'sh0002, 16'sh0003};
    send_elements(vals);
    wait_idle();
    apb_transfer(1'b1, REG_OP_MODE, {30'd0, OP_MIN}, rd);
    vals = '{16'sh0040, 16'sh8000, 16'sh7FFF, -16'sh0040, 16'sh0000, 16'sh1234};
    send_elements(vals);
    check_registers();
  endtask

  // An innermost length beyond the limit is clamped; each beat is its own mean, and the
  // start of the shortened walk carries no final mark.
  task automatic test_dim_clamp();
    logic [DIM_REG_W-1:0] dims [4];
    send_idle_pct  = 15;
    recv_stall_pct = 15;
    dims = '{13'd1, 13'd1, 13'd1, 13'h1FFF};
    configure(OP_MEAN, dims, 2'd0);
    send_random(64);
  endtask

  // An inner span one past the store depth makes entries alias; the second row starts on
  // the entry that the end of the first row overwrote.
  task automatic test_store_aliasing();
    logic [DIM_REG_W-1:0] dims [4];
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    dims = '{13'd2, 13'd1, 13'd1, DIM_REG_W'(STORE_DEPTH + 1)};
    configure(OP_SUM, dims, 2'd0);
    send_random(STORE_DEPTH + 3);
  endtask

  // The receiver holds off for a long stretch while element beats keep coming, so the
  // core has to fill up and push back on its input.
  task automatic test_backpressure();
    logic [DIM_REG_W-1:0] dims [4];
    dims = '{13'd1, 13'd1, 13'd64, 13'd4};
    configure(OP_SUM, dims, 2'd3);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holdoff_len    = 400;
    holdoff_seq++;
    send_random(128);
  endtask

  task automatic test_random_tensors(input int idle_pct, input int stall_pct,
                                     input int target);
    logic [DIM_REG_W-1:0] dims [4];
    logic [31:0]          rd;
    int                   sent;
    int                   total;
    int                   len;
    int                   part;
    int                   tensors;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < target) begin
      total = 1;
      for (int k = 0; k < 4; k++) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4);
        if (total * len > 64)
          len = 1;
        total *= len;
        dims[k] = (len == 1 && $urandom_range(15) == 0) ? '0 : len[DIM_REG_W-1:0];
      end
      configure(op_mode_t'($urandom_range(3)), dims, 2'($urandom_range(3)));
      tensors = $urandom_range(1, 3);
      repeat (tensors) send_random(total);
      sent += tensors * total;
      // Now and then a tensor is broken off part way, sometimes with a stray write to an
      // unused index in the middle; the next configuration restarts the walk.
      if (total > 1 && $urandom_range(4) == 0) begin
        part = $urandom_range(1, total - 1);
        send_random(part);
        sent += part;
        if ($urandom_range(1) == 0) begin
          wait_idle();
          apb_transfer(1'b1, REG_SPARE_B, $urandom, rd);
          part = $urandom_range(0, total - part);
          send_random(part);
          sent += part;
        end
      end
    end
  endtask

  initial begin
    red_op   = OP_SUM;
    red_axis = '0;
    foreach (dim_reg[k]) dim_reg[k] = 1;
    foreach (walk_pos[k]) walk_pos[k] = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_register_defaults();
    test_each_reduction();
    test_restart_and_ignored_writes();
    test_dim_clamp();
    test_store_aliasing();
    test_backpressure();
    test_random_tensors(0, 0, 150);
    test_random_tensors(74, 0, 150);
    test_random_tensors(0, 74, 150);
    test_random_tensors(15, 15, 150);

    wait_idle();
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
